### rtl/kss_pkg.sv
package kss_pkg;

    localparam int KEY_W  = 32;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_SCAN,
        ST_CHECK,
        ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic start;     // capture query, clear candidate
        logic pick;      // request candidate read
        logic scan;      // step the scan counter
        logic next_cand; // move to next candidate
        logic load_out;  // latch result
        logic err;       // result is a rank error
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic rank_bad;
        logic scan_done;
        logic hit;
        logic cand_done;
    } dp_stat_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

### rtl/kss_ram.sv
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/kss_ctrl.sv
module kss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_go,
    input  kss_pkg::dp_stat_t stat,
    input  logic              out_free,
    output logic              busy,
    output kss_pkg::dp_cmd_t  cmd
);
    import kss_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (stat.rank_bad)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.hit || stat.cand_done)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.next_cand = 1'b1;
                    state_next    = ST_PICK;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.err      = stat.rank_bad || !stat.hit;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/kss_dp.sv
module kss_dp #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kss_pkg::dp_cmd_t          cmd,
    input  logic                      wr_en,
    input  logic [kss_pkg::POS_W-1:0] wr_pos,
    input  logic [kss_pkg::KEY_W-1:0] wr_key,
    input  logic [kss_pkg::POS_W-1:0] q_rank,
    input  logic [kss_pkg::CNT_W-1:0] entries,
    output kss_pkg::dp_stat_t         stat,
    output logic [kss_pkg::KEY_W-1:0] res_key,
    output logic [kss_pkg::POS_W-1:0] res_pos
);
    import kss_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;

    logic [CW-1:0]       n_reg;
    logic [POS_W-1:0]    rank_reg;
    logic [CW-1:0]       cand_reg;
    logic [CW-1:0]       scan_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic                rd_vld_reg;
    logic [KEY_W-1:0]    cand_key_reg;
    logic                cand_ld_reg;
    logic [CW-1:0]       before_reg;
    logic [KEY_W-1:0]    rdata;
    logic [AW-1:0]       raddr;
    logic [POS_W+AW-1:0] wr_pos_w;
    logic                wr_ok;
    logic [CW-1:0]       n_next;
    logic                less;
    logic                cand_now;

    assign wr_pos_w = {{AW{1'b0}}, wr_pos};
    assign wr_ok = wr_en && (wr_pos_w < (POS_W+AW)'(MAX_ENTRIES));
    assign raddr = cmd.pick ? cand_reg[AW-1:0] : scan_reg[AW-1:0];

    kss_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (wr_pos_w[AW-1:0]),
        .wdata (wr_key),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (32'(entries) > 32'(MAX_ENTRIES))
        begin
            n_next = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_next = CW'(entries);
        end
    end

    assign less = ($signed(rdata) < $signed(cand_key_reg)) ||
                  ((rdata == cand_key_reg) && (rd_idx_reg < cand_reg));
    assign cand_now = cmd.pick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            cand_ld_reg <= 1'b0;
            scan_reg    <= '0;
        end
        else
        begin
            cand_ld_reg <= cand_now;
            rd_vld_reg  <= cmd.scan && !cand_ld_reg && (scan_reg < n_reg);
            if (cmd.pick)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan && !cand_ld_reg && scan_reg < n_reg)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg;
        if (cmd.start)
        begin
            n_reg    <= n_next;
            rank_reg <= q_rank;
            cand_reg <= '0;
        end
        if (cmd.next_cand)
        begin
            cand_reg <= cand_reg + 1'b1;
        end
        if (cmd.pick)
        begin
            before_reg <= '0;
        end
        if (cand_ld_reg)
        begin
            cand_key_reg <= rdata;
        end
        else if (rd_vld_reg && less)
        begin
            before_reg <= before_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            res_key <= cmd.err ? '0 : cand_key_reg;
            res_pos <= cmd.err ? '0 : POS_W'(cand_reg);
        end
    end

    assign stat.rank_bad  = ((POS_W+CW)'(rank_reg) >= (POS_W+CW)'(n_reg));
    assign stat.scan_done = (scan_reg == n_reg) && !rd_vld_reg && !cand_ld_reg;
    assign stat.hit       = (before_reg == CW'(rank_reg));
    assign stat.cand_done = (cand_reg + 1'b1 >= n_reg);

endmodule

### rtl/kth_smallest_select_core.sv
// kth_smallest_select_core: k-th smallest key selection over a key table.
// Input stream s_axis: tdata carries command, position, key_value, rank.
// A write (command 0) stores a key and returns no beat.
// A query (command 1) returns one beat on m_axis: key, position, error.
// Selection tries each position as candidate in turn and counts, with one
// comparator and one RAM read port, how many keys sort before it (signed
// key, then lower position). A rank error result is given without a scan.
// The core takes no new beat while a query is in progress; writes are
// taken whenever the core is idle.
// cfg_we/cfg_data write entries_in_use, saturated to MAX_ENTRIES on use.
// Reset clears control state and sets entries_in_use to 1024; table contents
// are undefined until written. If m_axis stalls, the result is held in the
// output register; new beats are still taken, and a following query waits
// for the register to drain before it loads its own result.
module kth_smallest_select_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] command, [10:1] position, [42:11] key_value, [52:43] rank
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] selected_key, [41:32] selected_position, [42] rank_error
    output logic [47:0] m_axis_tdata
);
    import kss_pkg::*;

    logic [CNT_W-1:0] entries_reg;
    logic             accept;
    logic             busy;
    logic             out_vld_reg;
    logic             err_reg;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [KEY_W-1:0] res_key;
    logic [POS_W-1:0] res_pos;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= 11'd1024;
            out_vld_reg <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
                err_reg     <= cmd.err;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    kss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .query_go (accept && s_axis_tdata[0] == CMD_QUERY),
        .stat     (stat),
        .out_free (!out_vld_reg),
        .busy     (busy),
        .cmd      (cmd)
    );

    kss_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_en   (accept && s_axis_tdata[0] == CMD_WRITE),
        .wr_pos  (s_axis_tdata[10:1]),
        .wr_key  (s_axis_tdata[42:11]),
        .q_rank  (s_axis_tdata[52:43]),
        .entries (entries_reg),
        .stat    (stat),
        .res_key (res_key),
        .res_pos (res_pos)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'd0, err_reg, res_pos, res_key};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("beat accepted while busy");
    a_load_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_vld_reg)
        else $error("result overwritten");
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("result not shown");

endmodule
